/* rtl/core/lzw12_pkg.sv */
// Shared types, constants and the slot hash for the 12-bit LZW encoder.
// No dependencies; used by lzw12_outq, lzw_encoder_12bit and the testbench.
`default_nettype none

package lzw12_pkg;

  localparam int CODE_BITS   = 12;
  localparam int SYMBOL_BITS = 7;
  localparam int HASH_DEPTH  = 8192;
  localparam int SLOT_BITS   = $clog2(HASH_DEPTH);
  localparam int KEY_BITS    = CODE_BITS + SYMBOL_BITS;
  localparam int NFC_BITS    = CODE_BITS + 1;
  localparam int EPOCH_BITS  = 4;

  localparam logic [NFC_BITS-1:0]   FIRST_FREE = NFC_BITS'(1 << SYMBOL_BITS);
  localparam logic [SLOT_BITS-1:0]  SLOT_LAST  = SLOT_BITS'(HASH_DEPTH - 1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = {EPOCH_BITS{1'b1}};
  localparam logic [31:0]           HASH_MULT  = 32'd2654435761;

  // output queue geometry
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = OQ_PTR_BITS + 1;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last_code;
  } out_word_t;

  // one dictionary slot: key half and code half in one RAM word
  typedef struct packed {
    logic                  valid;
    logic [EPOCH_BITS-1:0] epoch;
    logic [KEY_BITS-1:0]   key;
    logic [CODE_BITS-1:0]  code;
  } entry_t;

  // up to two result words pushed by one item
  typedef struct packed {
    logic      valid0;
    out_word_t word0;
    logic      valid1;
    out_word_t word1;
  } push_t;

  // multiplicative hash, bits [19:7] of the low product word
  function automatic logic [SLOT_BITS-1:0] hash_slot(input logic [KEY_BITS-1:0] key);
    logic [31:0] prod;
    prod = 32'(key) * HASH_MULT;
    return prod[SLOT_BITS+6:7];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lzw12_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module lzw12_ram #(
  parameter int WIDTH     = 36,
  parameter int DEPTH     = 8192,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/lzw12_outq.sv */
// Small result queue; takes up to two words per cycle, hands out one per cycle while out_ready is high.
// Depends on lzw12_pkg.
`default_nettype none

module lzw12_outq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lzw12_pkg::push_t      push,
  output logic                       room2,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lzw12_pkg::out_word_t       out_data
);

  lzw12_pkg::out_word_t q_r [lzw12_pkg::OQ_DEPTH];

  logic [lzw12_pkg::OQ_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lzw12_pkg::OQ_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lzw12_pkg::OQ_CNT_BITS-1:0] count_r, count_nxt;
  logic [lzw12_pkg::OQ_PTR_BITS-1:0] wr_ptr1;
  logic                              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign room2     = (count_r <= lzw12_pkg::OQ_CNT_BITS'(lzw12_pkg::OQ_DEPTH - 2));
  assign wr_ptr1   = wr_ptr_r + lzw12_pkg::OQ_PTR_BITS'(push.valid0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lzw12_pkg::OQ_PTR_BITS'(push.valid0)
                          + lzw12_pkg::OQ_PTR_BITS'(push.valid1);
    rd_ptr_nxt = rd_ptr_r + lzw12_pkg::OQ_PTR_BITS'(pop);
    count_nxt  = count_r + lzw12_pkg::OQ_CNT_BITS'(push.valid0)
                         + lzw12_pkg::OQ_CNT_BITS'(push.valid1)
                         - lzw12_pkg::OQ_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      q_r[wr_ptr_r] <= push.word0;
    end
    if (push.valid1) begin
      q_r[wr_ptr1] <= push.word1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lzw_encoder_12bit.sv */
// LZW encoder, 12-bit codes. An item after a stream's first word goes through accept+hash,
// RAM read and compare, with a further compare per extra linear probe; the single-read-port
// dictionary RAM sets this pace. Results leave through a 4-word queue in the cycle after the
// one that pushes them at the earliest. Reset (sync, rst_n low) starts a clearing pass over
// all 8192 slots with in_ready low; the same pass follows every 16th end of stream, when the
// 4-bit stream epoch wraps. Depends on lzw12_pkg, lzw12_ram, lzw12_outq.
`default_nettype none

module lzw_encoder_12bit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lzw12_pkg::in_word_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lzw12_pkg::out_word_t       out_data
);

  // S_CLEAR  : sweep every slot to invalid
  // S_IDLE   : wait for a word; on accept, hash (prefix, symbol) or load a stream's first word
  // S_READ   : RAM read of the home slot in flight
  // S_CHECK  : compare; probe the next slot on a foreign key
  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK} state_t;

  state_t                                  state_r, state_nxt;
  logic [lzw12_pkg::CODE_BITS-1:0]         prefix_r, prefix_nxt;
  logic                                    pvalid_r, pvalid_nxt;
  logic [lzw12_pkg::NFC_BITS-1:0]          next_free_r, next_free_nxt;
  logic [lzw12_pkg::EPOCH_BITS-1:0]        epoch_r, epoch_nxt;
  logic [lzw12_pkg::SLOT_BITS-1:0]         slot_r, slot_nxt;
  logic [lzw12_pkg::SLOT_BITS-1:0]         clr_addr_r, clr_addr_nxt;
  logic [lzw12_pkg::SYMBOL_BITS-1:0]       sym_r, sym_nxt;
  logic                                    last_r, last_nxt;

  // dictionary RAM port
  logic                                    ram_we;
  logic [lzw12_pkg::SLOT_BITS-1:0]         ram_waddr;
  lzw12_pkg::entry_t                       ram_wentry;
  logic [lzw12_pkg::SLOT_BITS-1:0]         ram_raddr;
  logic [$bits(lzw12_pkg::entry_t)-1:0]    ram_rdata;
  lzw12_pkg::entry_t                       rd_entry;

  lzw12_pkg::push_t                        push;
  logic                                    room2;
  logic                                    accept;
  logic [lzw12_pkg::KEY_BITS-1:0]          cur_key;
  logic                                    live;
  logic                                    hit;

  assign rd_entry = lzw12_pkg::entry_t'(ram_rdata);
  assign in_ready = (state_r == S_IDLE) && room2;
  assign accept   = in_valid && in_ready;
  assign cur_key  = {prefix_r, sym_r};

  // an entry only counts if written during the current stream
  assign live = rd_entry.valid && (rd_entry.epoch == epoch_r);
  assign hit  = live && (rd_entry.key == cur_key);

  // probing reads one slot ahead so the next slot is ready for the following compare
  assign ram_raddr = (state_r == S_CHECK) ? slot_r + 1'b1 : slot_r;

  always_comb begin
    state_nxt     = state_r;
    prefix_nxt    = prefix_r;
    pvalid_nxt    = pvalid_r;
    next_free_nxt = next_free_r;
    epoch_nxt     = epoch_r;
    slot_nxt      = slot_r;
    clr_addr_nxt  = clr_addr_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wentry    = '0;
    push          = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == lzw12_pkg::SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          sym_nxt  = in_data.symbol;
          last_nxt = in_data.end_of_stream;
          if (!pvalid_r) begin
            // first word of a stream loads the prefix; if also final, it is pushed at once
            prefix_nxt = lzw12_pkg::CODE_BITS'(in_data.symbol);
            pvalid_nxt = 1'b1;
            if (in_data.end_of_stream) begin
              push.valid0 = 1'b1;
              push.word0  = '{code: lzw12_pkg::CODE_BITS'(in_data.symbol), last_code: 1'b1};
            end
          end else begin
            slot_nxt  = lzw12_pkg::hash_slot({prefix_r, in_data.symbol});
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (hit) begin
          prefix_nxt = rd_entry.code;
          state_nxt  = S_IDLE;
        end else if (!live) begin
          // miss: emit prefix, insert pair while codes remain
          push.valid0 = 1'b1;
          push.word0  = '{code: prefix_r, last_code: 1'b0};
          if (!next_free_r[lzw12_pkg::NFC_BITS-1]) begin
            ram_we        = 1'b1;
            ram_waddr     = slot_r;
            ram_wentry    = '{valid: 1'b1, epoch: epoch_r, key: cur_key,
                              code: next_free_r[lzw12_pkg::CODE_BITS-1:0]};
            next_free_nxt = next_free_r + 1'b1;
          end
          prefix_nxt = lzw12_pkg::CODE_BITS'(sym_r);
          state_nxt  = S_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
        if ((hit || !live) && last_r) begin
          push.valid1 = 1'b1;
          push.word1  = '{code: prefix_nxt, last_code: 1'b1};
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // end of stream: fresh prefix and code space, new epoch; clearing pass on epoch wrap
    if ((push.valid0 && push.word0.last_code) || push.valid1) begin
      prefix_nxt    = '0;
      pvalid_nxt    = 1'b0;
      next_free_nxt = lzw12_pkg::FIRST_FREE;
      epoch_nxt     = epoch_r + 1'b1;
      if (epoch_r == lzw12_pkg::EPOCH_LAST) begin
        clr_addr_nxt = '0;
        state_nxt    = S_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      prefix_r    <= '0;
      pvalid_r    <= 1'b0;
      next_free_r <= lzw12_pkg::FIRST_FREE;
      epoch_r     <= '0;
      clr_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      prefix_r    <= prefix_nxt;
      pvalid_r    <= pvalid_nxt;
      next_free_r <= next_free_nxt;
      epoch_r     <= epoch_nxt;
      clr_addr_r  <= clr_addr_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
  end

  lzw12_ram #(
    .WIDTH ($bits(lzw12_pkg::entry_t)),
    .DEPTH (lzw12_pkg::HASH_DEPTH)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lzw12_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/tb_lzw_encoder_12bit.sv */
// Self-checking testbench for lzw_encoder_12bit: streams of characters in, LZW codes out.
// Depends on lzw12_pkg for the word types and the code and key widths.
// A scoreboard class keeps its own dictionary; tasks drive in_valid, an always block out_ready.

module tb_lzw_encoder_12bit;
  timeunit 1ns;
  timeprecision 1ps;

  import lzw12_pkg::*;

  localparam int CODE_MAX        = (1 << CODE_BITS) - 1;
  localparam int ALPHABET        = 1 << SYMBOL_BITS;
  localparam int HOLD_CYCLES     = 600;     // receiver back-pressure stretch
  localparam int DRAIN_CYCLES    = 24;      // quiet tail after the last code
  localparam int LONG_STREAM_LEN = 400;     // one long stream over the whole alphabet
  localparam longint TIMEOUT_NS = 4_000_000;

  // ---------------------------------------------------------------------------
  // Scoreboard: tracks prefix, next free code and the (prefix, char) -> code
  // map, and keeps the codes still owed by the block in arrival order.
  // ---------------------------------------------------------------------------
  class lzw_code_tracker;
    bit [CODE_BITS-1:0] prefix;
    bit                 has_prefix;
    int unsigned        free_code;
    bit [CODE_BITS-1:0] pair_code [bit [KEY_BITS-1:0]];
    out_word_t          expected_codes [$];
    int                 errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      prefix     = '0;
      has_prefix = 1'b0;
      free_code  = ALPHABET;
      pair_code.delete();
    endfunction

    function void owe_code(bit [CODE_BITS-1:0] c, bit last);
      out_word_t w;
      w.code      = c;
      w.last_code = last;
      expected_codes.push_back(w);
    endfunction

    // Note one accepted input word and queue the codes it produces.
    function void encode_symbol(in_word_t w);
      bit [KEY_BITS-1:0] pair;
      if (!has_prefix) begin
        prefix     = CODE_BITS'(w.symbol);
        has_prefix = 1'b1;
      end else begin
        pair = {prefix, w.symbol};
        if (pair_code.exists(pair)) begin
          prefix = pair_code[pair];
        end else begin
          owe_code(prefix, 1'b0);
          // once the code space is used up, misses no longer add entries
          if (free_code <= CODE_MAX) begin
            pair_code[pair] = CODE_BITS'(free_code);
            free_code++;
          end
          prefix = CODE_BITS'(w.symbol);
        end
      end
      if (w.end_of_stream) begin
        owe_code(prefix, 1'b1);
        restart();
      end
    endfunction

    // Compare one accepted result word with the oldest code owed.
    function void check_code(out_word_t got);
      out_word_t want;
      if (expected_codes.size() == 0) begin
        $error("unexpected word: code %0d last_code %0b", got.code, got.last_code);
        errors++;
        return;
      end
      want = expected_codes.pop_front();
      if (got.code !== want.code) begin
        $error("code: expected %0d, got %0d", want.code, got.code);
        errors++;
      end
      if (got.last_code !== want.last_code) begin
        $error("last_code: expected %0b, got %0b", want.last_code, got.last_code);
        errors++;
      end
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block hookup
  // ---------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // knobs set by the main sequence for driver and receiver; written with NBAs only
  logic      steady       = 1'b0;   // no idling on either side while set
  logic      hold_request = 1'b0;   // ask the receiver for one long stall

  int              words_sent = 0;
  int              hold_left  = 0;
  logic            hold_done  = 1'b0;
  lzw_code_tracker tracker    = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lzw_encoder_12bit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Receiver: checks every accepted code word and drives out_ready.
  // Values read here are the pre-edge ones, so the handshake sample is exact.
  // One NBA to out_ready per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      tracker.check_code(out_data);
    end
    if (hold_left != 0) begin
      // long stall: the output queue fills and the block must stop taking words
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word, holding it until accepted. Right after acceptance nothing
  // is assigned, so the next call owns the single NBA to in_valid in that step.
  task automatic send_word(input logic [SYMBOL_BITS-1:0] sym, input logic eos);
    in_word_t w;
    w.symbol        = sym;
    w.end_of_stream = eos;
    if (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.encode_symbol(w);
    words_sent++;
  endtask

  // One stream of len characters drawn from a window of alph characters.
  // Narrow windows give repeats, so prefixes grow through dictionary hits.
  task automatic random_stream(input int len, input int alph);
    int base;
    int k;
    base = $urandom_range(ALPHABET - alph);
    for (k = 0; k < len; k++) begin
      send_word(SYMBOL_BITS'(base + $urandom_range(alph - 1)), k == len - 1);
    end
  endtask

  // Short streams of mixed character windows until n words have gone in.
  task automatic short_streams(input int n);
    int stop;
    int len;
    int alph;
    stop = words_sent + n;
    while (words_sent < stop) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(150, 41) : $urandom_range(40, 1);
      case ($urandom_range(5))
        0: alph = 1;
        1: alph = 2;
        2: alph = 3;
        3: alph = 8;
        4: alph = 32;
        default: alph = ALPHABET;
      endcase
      random_stream(len, alph);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int k;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass after reset keeps in_ready low; send_word just waits

    // --- directed ---
    send_word(7'd0, 1'b1);                  // lone word: first and final at once, char zero
    send_word(7'd127, 1'b0);                // top character, repeated: miss then hit
    send_word(7'd127, 1'b0);
    send_word(7'd127, 1'b1);
    for (k = 0; k < 6; k++) begin           // run of zeros builds a chain of hits
      send_word(7'd0, k == 5);
    end
    for (k = 0; k < 8; k++) begin           // alternating bit patterns, final word misses
      send_word(k[0] ? 7'h2A : 7'h55, k == 7);
    end
    send_word(7'd1, 1'b0);                  // two-word stream: miss on the final word
    send_word(7'd2, 1'b1);

    // --- random ---
    hold_request <= 1'b1;                   // receiver stalls once, early on
    short_streams(900);
    steady <= 1'b1;                         // stretch with no idling either side
    short_streams(300);
    steady <= 1'b0;
    // one long stream of all characters: mostly misses, many dictionary inserts
    random_stream(LONG_STREAM_LEN, ALPHABET);
    short_streams(130);

    in_valid <= 1'b0;

    // --- drain ---
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog: hung handshake or lost codes
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/core/lzw12_pkg.sv
rtl/core/lzw12_ram.sv
rtl/core/lzw12_outq.sv
rtl/core/lzw_encoder_12bit.sv
tb/tb_lzw_encoder_12bit.sv
